>>> rtl/ssr_pkg.sv
package ssr_pkg;

    localparam int PATTERN_MAX_DEF = 8;
    localparam int REPLACE_MAX_DEF = 8;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 4;
    localparam int LIMIT_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LIMIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLED     = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_REPL,
        ST_MARK
    } ssr_state_t;

    // command broadcast to every window cell
    typedef struct packed {
        logic load;
        logic shift;
        logic clear;
    } cell_cmd_t;

    // window status gathered from the cell chain
    typedef struct packed {
        logic occ_any;
        logic occ_one;
        logic prefix;
        logic full_match;
    } chain_stat_t;

endpackage

>>> rtl/streaming_substring_replace_core.sv
// Streaming find-and-replace on a byte stream. Bytes enter on s_*, results leave on m_*;
// every leftmost, non-overlapping occurrence of the pattern (1..PATTERN_MAX bytes) is
// replaced by 0..REPLACE_MAX replacement bytes, optionally capped at replace_limit
// replacements per stream. Bytes that may still start a match wait in a chain of
// PATTERN_MAX window cells; s_in_last flushes the window, and a stream end that
// produces no byte returns one result with m_out_valid low and m_out_last high.
// One byte is handled at a time: a new input byte is taken only once the block is done
// with the last one. The window chain shifts out one byte per cycle and the single
// output register is loaded with one result per cycle, each only while m_ready does
// not hold the output stalled. Configure only while idle; a pattern length of zero
// passes text through unchanged.
module streaming_substring_replace_core #(
    parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEF,
    parameter int REPLACE_MAX = ssr_pkg::REPLACE_MAX_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ssr_pkg::BYTE_W-1:0]       s_in_byte,
    input  logic                             s_in_last,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ssr_pkg::BYTE_W-1:0]       m_out_byte,
    output logic                             m_out_valid,
    output logic                             m_out_last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ssr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ssr_pkg::*;

    localparam int PLEN_W = $clog2(PATTERN_MAX + 1);
    localparam int RLEN_W = $clog2(REPLACE_MAX + 1);
    localparam int RIDX_W = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

    logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_reg;
    logic [LEN_W-1:0]                   plen_reg;
    logic [REPLACE_MAX-1:0][BYTE_W-1:0] repl_reg;
    logic [LEN_W-1:0]                   rlen_reg;
    logic [LIMIT_W-1:0]                 limit_reg;
    logic                               limen_reg;

    logic [PLEN_W-1:0]                  plen_c;
    logic [PLEN_W-1:0]                  plen_m1;
    logic [RLEN_W-1:0]                  rlen_c;

    cell_cmd_t                          cell_cmd;
    chain_stat_t                        stat;
    logic [RIDX_W-1:0]                  ridx;

    logic [PATTERN_MAX-1:0][BYTE_W-1:0] cell_byte;
    logic [PATTERN_MAX:0]               occ_ext;
    logic [PATTERN_MAX-1:0]             cell_ok;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg   <= '0;
            plen_reg  <= LEN_W'(1);
            repl_reg  <= '0;
            rlen_reg  <= '0;
            limit_reg <= '1;
            limen_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PATTERN_BYTES:     pat_reg   <= cfg_data[PATTERN_MAX*BYTE_W-1:0];
                CFG_PATTERN_LENGTH:    plen_reg  <= cfg_data[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES: repl_reg  <= cfg_data[REPLACE_MAX*BYTE_W-1:0];
                CFG_REPLACEMENT_LEN:   rlen_reg  <= cfg_data[LEN_W-1:0];
                CFG_REPLACE_LIMIT:     limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_LIMIT_ENABLED:     limen_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // oversized lengths count as the maximum
    assign plen_c  = (plen_reg > LEN_W'(PATTERN_MAX)) ? PLEN_W'(PATTERN_MAX)
                                                       : plen_reg[PLEN_W-1:0];
    assign rlen_c  = (rlen_reg > LEN_W'(REPLACE_MAX)) ? RLEN_W'(REPLACE_MAX)
                                                       : rlen_reg[RLEN_W-1:0];
    assign plen_m1 = plen_c - PLEN_W'(1);

    assign occ_ext[PATTERN_MAX] = 1'b0;

    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        logic              left_occ;
        logic [BYTE_W-1:0] right_byte;

        if (i == 0) begin : g_head
            assign left_occ = 1'b1;
        end else begin : g_body
            assign left_occ = occ_ext[i-1];
        end
        if (i == PATTERN_MAX - 1) begin : g_tail
            assign right_byte = '0;
        end else begin : g_inner
            assign right_byte = cell_byte[i+1];
        end

        ssr_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cell_cmd),
            .load_byte  (s_in_byte),
            .left_occ   (left_occ),
            .right_byte (right_byte),
            .right_occ  (occ_ext[i+1]),
            .pat_byte   (pat_reg[i]),
            .pat_used   (PLEN_W'(i) < plen_c),
            .cell_byte  (cell_byte[i]),
            .cell_occ   (occ_ext[i]),
            .cell_ok    (cell_ok[i])
        );
    end

    assign stat.occ_any    = occ_ext[0];
    assign stat.occ_one    = occ_ext[0] && !occ_ext[1];
    assign stat.prefix     = &cell_ok;
    assign stat.full_match = (plen_c != '0) && occ_ext[plen_m1] && !occ_ext[plen_c];

    ssr_ctrl #(
        .REPLACE_MAX (REPLACE_MAX),
        .RLEN_W      (RLEN_W),
        .RIDX_W      (RIDX_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_last     (s_in_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_out_valid   (m_out_valid),
        .m_out_last    (m_out_last),
        .stat          (stat),
        .front_byte    (cell_byte[0]),
        .repl_byte     (repl_reg[ridx]),
        .rlen          (rlen_c),
        .plen_zero     (plen_c == '0),
        .replace_limit (limit_reg),
        .limit_enabled (limen_reg),
        .cell_cmd      (cell_cmd),
        .ridx          (ridx)
    );

endmodule

>>> rtl/ssr_cell.sv
module ssr_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ssr_pkg::cell_cmd_t             cmd,
    input  logic [ssr_pkg::BYTE_W-1:0]     load_byte,
    input  logic                           left_occ,
    input  logic [ssr_pkg::BYTE_W-1:0]     right_byte,
    input  logic                           right_occ,
    input  logic [ssr_pkg::BYTE_W-1:0]     pat_byte,
    input  logic                           pat_used,
    output logic [ssr_pkg::BYTE_W-1:0]     cell_byte,
    output logic                           cell_occ,
    output logic                           cell_ok
);
    import ssr_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              occ_reg;
    logic              occ_next;

    // the first free cell takes the incoming byte
    always_comb begin
        byte_next = byte_reg;
        occ_next  = occ_reg;
        priority if (cmd.clear) begin
            occ_next = 1'b0;
        end else if (cmd.shift) begin
            byte_next = right_byte;
            occ_next  = right_occ;
        end else if (cmd.load && left_occ && !occ_reg) begin
            byte_next = load_byte;
            occ_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
        byte_reg <= byte_next;
    end

    assign cell_byte = byte_reg;
    assign cell_occ  = occ_reg;
    assign cell_ok   = !occ_reg || (pat_used && (byte_reg == pat_byte));

endmodule

>>> rtl/ssr_ctrl.sv
module ssr_ctrl #(
    parameter int REPLACE_MAX = ssr_pkg::REPLACE_MAX_DEF,
    parameter int RLEN_W      = $clog2(REPLACE_MAX + 1),
    parameter int RIDX_W      = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_in_last,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ssr_pkg::BYTE_W-1:0]     m_out_byte,
    output logic                           m_out_valid,
    output logic                           m_out_last,
    input  ssr_pkg::chain_stat_t           stat,
    input  logic [ssr_pkg::BYTE_W-1:0]     front_byte,
    input  logic [ssr_pkg::BYTE_W-1:0]     repl_byte,
    input  logic [RLEN_W-1:0]              rlen,
    input  logic                           plen_zero,
    input  logic [ssr_pkg::LIMIT_W-1:0]    replace_limit,
    input  logic                           limit_enabled,
    output ssr_pkg::cell_cmd_t             cell_cmd,
    output logic [RIDX_W-1:0]              ridx
);
    import ssr_pkg::*;

    ssr_state_t        state_reg;
    ssr_state_t        state_next;
    ssr_state_t        fin_state;
    logic              last_reg;
    logic              emitted_reg;
    logic [RIDX_W-1:0] ridx_reg;
    logic [LIMIT_W-1:0] count_reg;
    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_byte_reg;
    logic              m_dv_reg;
    logic              m_last_reg;

    logic              allowed;
    logic              emit_ok;
    logic              repl_end;
    logic              emit;
    logic [BYTE_W-1:0] e_byte;
    logic              e_dv;
    logic              e_last;
    logic              count_inc;
    logic              item_done;

    assign allowed  = !plen_zero && (!limit_enabled || (count_reg < replace_limit));
    assign emit_ok  = !m_valid_reg || m_ready;
    assign repl_end = (RLEN_W'(ridx_reg) + RLEN_W'(1)) == rlen;
    // a stream that produced nothing still owes an end marker
    assign fin_state = (last_reg && !emitted_reg) ? ST_MARK : ST_IDLE;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                priority if (!allowed) begin
                    state_next = ST_FLUSH;
                end else if (stat.occ_any && !stat.prefix) begin
                    state_next = ST_SCAN;
                end else if (stat.full_match) begin
                    state_next = (rlen != '0) ? ST_REPL : fin_state;
                end else if (last_reg && stat.occ_any) begin
                    state_next = ST_FLUSH;
                end else begin
                    state_next = fin_state;
                end
            end
            ST_FLUSH: begin
                if (!stat.occ_any) begin
                    state_next = fin_state;
                end else if (emit_ok && stat.occ_one) begin
                    state_next = ST_IDLE;
                end
            end
            ST_REPL: begin
                if (emit_ok && repl_end) state_next = ST_IDLE;
            end
            ST_MARK: begin
                if (emit_ok) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        emit      = 1'b0;
        e_byte    = front_byte;
        e_dv      = 1'b1;
        e_last    = 1'b0;
        count_inc = 1'b0;
        cell_cmd  = '0;
        s_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cell_cmd.load = s_valid;
            end
            ST_SCAN: begin
                if (allowed && stat.occ_any && !stat.prefix) begin
                    if (emit_ok) begin
                        emit           = 1'b1;
                        e_last         = last_reg && stat.occ_one;
                        cell_cmd.shift = 1'b1;
                    end
                end else if (allowed && stat.full_match) begin
                    cell_cmd.clear = 1'b1;
                    count_inc      = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (stat.occ_any && emit_ok) begin
                    emit           = 1'b1;
                    e_last         = last_reg && stat.occ_one;
                    cell_cmd.shift = 1'b1;
                end
            end
            ST_REPL: begin
                if (emit_ok) begin
                    emit   = 1'b1;
                    e_byte = repl_byte;
                    e_last = last_reg && repl_end;
                end
            end
            ST_MARK: begin
                if (emit_ok) begin
                    emit   = 1'b1;
                    e_byte = '0;
                    e_dv   = 1'b0;
                    e_last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign item_done = (state_reg != ST_IDLE) && (state_next == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            last_reg    <= 1'b0;
            emitted_reg <= 1'b0;
            ridx_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cell_cmd.load) begin
                last_reg    <= s_in_last;
                emitted_reg <= 1'b0;
            end else if (emit) begin
                emitted_reg <= 1'b1;
            end
            if (state_reg != ST_REPL) begin
                ridx_reg <= '0;
            end else if (emit) begin
                ridx_reg <= ridx_reg + RIDX_W'(1);
            end
            if (item_done && last_reg) begin
                count_reg <= '0;
            end else if (count_inc && (count_reg != '1)) begin
                count_reg <= count_reg + LIMIT_W'(1);
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (emit) begin
            m_byte_reg <= e_byte;
            m_dv_reg   <= e_dv;
            m_last_reg <= e_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = m_byte_reg;
    assign m_out_valid = m_dv_reg;
    assign m_out_last  = m_last_reg;
    assign ridx        = ridx_reg;

endmodule

>>> rtl/ssr_checker.sv
module ssr_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [ssr_pkg::BYTE_W-1:0]       m_out_byte,
    input logic                             m_out_valid,
    input logic                             m_out_last
);
    import ssr_pkg::*;

    // a stalled result must not change
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
                                && $stable(m_out_valid) && $stable(m_out_last))
        else $error("result changed while stalled");

    // empty end marker closes a stream and carries a zero byte
    a_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_valid |-> m_out_last && (m_out_byte == '0))
        else $error("empty marker malformed");

    // one byte in flight at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second byte taken while busy");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind streaming_substring_replace_core ssr_checker u_ssr_checker (.*);
